@@ hdl/smx_pkg.sv @@
// Shared type, constants and helper function for the row softmax normalizer.
package smx_pkg;

  localparam int ROW_MAX = 16;
  localparam int IDX_W = $clog2(ROW_MAX);
  localparam int CNT_W = $clog2(ROW_MAX + 1);
  localparam int ElemW = 16;
  localparam int ExpW = 17;
  localparam int SumW = 21;
  localparam int ProbW = 16;
  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP_WR,
    ST_DIV_RD,
    ST_DIV_RUN,
    ST_OUT
  } smx_state_t;

  // Table of 2^(-i/16) in Q16.
  function automatic logic [16:0] pow2_lut(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0: v = 17'd65536;
      5'd1: v = 17'd62757;
      5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;
      5'd4: v = 17'd55109;
      5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;
      5'd7: v = 17'd48393;
      5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/smx_in_if.sv @@
// Input channel interface carrying one row element per item.
interface smx_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

@@ hdl/smx_out_if.sv @@
// Result channel interface carrying one probability per item.
interface smx_out_if;
  logic valid;
  logic ready;
  logic [15:0] probability;
  logic [3:0] element_index;
  logic last_in_row;
  modport source (output valid, output probability, output element_index,
                  output last_in_row, input ready);
  modport sink (input valid, input probability, input element_index,
                input last_in_row, output ready);
endinterface

@@ hdl/softmax_row_normalizer.sv @@
// Top level of the row softmax normalizer.
// Elements of a row are accepted one per cycle into a 16-entry row memory
// while the row maximum is tracked. The element that completes the row
// (row_length, clamped to 1..16) starts an exponent pass over the memory,
// then a division pass in which each element in turn is divided (one
// quotient bit a cycle in a shared divider) and then sent over the output
// handshake. No input is taken until the row's last result has left.
module softmax_row_normalizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  smx_in_if.sink     in_ch,
  smx_out_if.source  out_ch
);
  import smx_pkg::*;

  logic [ElemW-1:0] row_mem [ROW_MAX];
  logic [ExpW-1:0]  exp_mem [ROW_MAX];
  logic [ElemW-1:0] row_rd_r;
  logic [ExpW-1:0]  exp_rd_r;

  smx_state_t state_r, state_nxt;
  logic [4:0]         len_r;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic signed [15:0] max_r, max_nxt;
  logic [SumW-1:0]    sum_r, sum_nxt;
  logic [ProbW-1:0]   prob_r, prob_nxt;
  logic               wait_r, wait_nxt;

  logic [CNT_W-1:0]   eff_len;
  logic [IDX_W-1:0]   wr_slot;
  logic               accept;
  logic               exp_we;
  logic [ExpW-1:0]    exp_val;
  logic               div_start;
  logic               div_done;
  logic [32:0]        div_q;
  logic signed [16:0] diff;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 5'd16;
    end else if (cfg_we) begin
      len_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (len_r == 5'd0) eff_len = CNT_W'(1);
    else if (len_r > 5'(ROW_MAX)) eff_len = CNT_W'(ROW_MAX);
    else eff_len = CNT_W'(len_r);
  end

  assign accept  = in_ch.valid && in_ch.ready;
  assign wr_slot = (fill_r >= CNT_W'(ROW_MAX)) ? IDX_W'(ROW_MAX - 1) : fill_r[IDX_W-1:0];
  assign diff    = 17'(signed'(row_rd_r)) - 17'(max_r);

  // Row and exponent memories with registered read.
  always_ff @(posedge clk) begin
    if (accept) row_mem[wr_slot] <= in_ch.element_value;
    if (exp_we) exp_mem[idx_r[IDX_W-1:0]] <= exp_val;
    row_rd_r <= row_mem[idx_r[IDX_W-1:0]];
    exp_rd_r <= exp_mem[idx_r[IDX_W-1:0]];
  end

  smx_exp_unit u_exp (.clk(clk), .diff(diff), .exp_val(exp_val));

  smx_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(33'(exp_rd_r) * 33'd65535), .den(sum_r),
    .done(div_done), .quot(div_q)
  );

  // Sequencer: load, exponent pass, division and output pass.
  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    prob_nxt = prob_r;
    wait_nxt = wait_r;
    exp_we = 1'b0;
    div_start = 1'b0;
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.element_value > max_r) max_nxt = in_ch.element_value;
          if (CNT_W'(wr_slot) + CNT_W'(1) >= eff_len) begin
            count_nxt = CNT_W'(wr_slot) + CNT_W'(1);
            idx_nxt = '0;
            sum_nxt = '0;
            state_nxt = ST_EXP_RD;
          end else begin
            fill_nxt = CNT_W'(wr_slot) + CNT_W'(1);
          end
        end
      end
      ST_EXP_RD: begin
        wait_nxt = 1'b0;
        state_nxt = ST_EXP_WR;
      end
      ST_EXP_WR: begin
        // Row read lands here; the exponent is written once it has passed the exponent unit's registered first stage.
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else begin
          exp_we = 1'b1;
          sum_nxt = sum_r + SumW'(exp_val);
          wait_nxt = 1'b0;
          if (idx_r + CNT_W'(1) == count_r) begin
            idx_nxt = '0;
            state_nxt = ST_DIV_RD;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            state_nxt = ST_EXP_RD;
          end
        end
      end
      ST_DIV_RD: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else begin
          wait_nxt = 1'b0;
          div_start = 1'b1;
          state_nxt = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        if (div_done) begin
          if (sum_r == '0) prob_nxt = '0;
          else if (div_q > 33'd65535) prob_nxt = 16'hFFFF;
          else prob_nxt = div_q[15:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          if (idx_r + CNT_W'(1) == count_r) begin
            fill_nxt = '0;
            max_nxt = 16'sh8000;
            sum_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            state_nxt = ST_DIV_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    prob_r <= prob_nxt;
    count_r <= count_nxt;
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r <= '0;
      idx_r <= '0;
      max_r <= 16'sh8000;
      sum_r <= '0;
      wait_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      idx_r <= idx_nxt;
      max_r <= max_nxt;
      sum_r <= sum_nxt;
      wait_r <= wait_nxt;
    end
  end

  assign out_ch.probability   = prob_r;
  assign out_ch.element_index = idx_r[IDX_W-1:0];
  assign out_ch.last_in_row   = (idx_r + CNT_W'(1) == count_r);
endmodule

@@ hdl/smx_exp_unit.sv @@
// Pipelined exponent unit: exp(d) for d <= 0 in Q8.8 giving Q1.16.
module smx_exp_unit (
  input  logic                      clk,
  input  logic signed [16:0]        diff,
  output logic [smx_pkg::ExpW-1:0]  exp_val
);
  import smx_pkg::*;

  logic        zero_r;
  logic [33:0] y_r;
  logic [16:0] hi;
  logic [16:0] lo;
  logic [29:0] prod;
  logic [16:0] m;
  logic [7:0]  n;
  logic [16:0] mag;

  // Stage one: scale the magnitude by log2(e).
  assign mag = 17'(-diff);
  always_ff @(posedge clk) begin
    zero_r <= (diff < -17'sd4096);
    y_r    <= 34'(mag) * 34'(Log2eQ16);
  end

  // Stage two: interpolate the table and shift by the integer part.
  assign hi   = pow2_lut({1'b0, y_r[23:20]});
  assign lo   = pow2_lut(5'({1'b0, y_r[23:20]}) + 5'd1);
  assign prod = 30'(hi - lo) * 30'(y_r[19:8]);
  assign m    = hi - 17'(prod >> 12);
  assign n    = 8'(y_r[33:24]);
  always_comb begin
    if (zero_r || n >= 8'd17) begin
      exp_val = '0;
    end else begin
      exp_val = m >> n;
    end
  end
endmodule

@@ hdl/smx_divider.sv @@
// Restoring divider: floor(num / den), one quotient bit per cycle.
module smx_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [20:0] den,
  output logic        done,
  output logic [32:0] quot
);
  import smx_pkg::*;

  logic [32:0] q_r, q_nxt;
  logic [21:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [21:0] trial;

  // One shift-subtract step per cycle.
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = '0;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[20:0], q_r[32]};
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt = {q_r[31:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign done = busy_r && cnt_r == 6'd1;
  assign quot = q_nxt;
endmodule
